### src/scanline_polygon_row_fill_defines.svh
// Assertion macros shared by the scanline polygon row fill RTL.
`ifndef SCANLINE_POLYGON_ROW_FILL_DEFINES_SVH
`define SCANLINE_POLYGON_ROW_FILL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define SPLF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("splf assertion failed");
// Next-cycle implication.
`define SPLF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("splf assertion failed");
`else
`define SPLF_ASSERT_SAME(label, ante, cons)
`define SPLF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/splf_pkg.sv
// Shared types and constants of the scanline polygon row fill block.
package splf_pkg;

    localparam int unsigned CFG_BITS  = 11;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd800;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd600;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_FILL   = 2'd2;

    // Control of the sorting chain, broadcast to every cell.
    typedef struct packed {
        logic clr;
        logic shift;
    } t_cell_ctl;

endpackage

### src/splf_div.sv
// Iterative restoring divider, one quotient bit per cycle, unsigned magnitudes.
module splf_div #(
    parameter int unsigned NUM_W = 20,
    parameter int unsigned DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int unsigned CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

### src/splf_cell.sv
// One cell of the systolic insertion-sort chain of crossings.
module splf_cell #(
    parameter int unsigned W = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  splf_pkg::t_cell_ctl i_ctl,
    input  logic                i_ins_v,
    input  logic [W-1:0]        i_ins_val,
    input  logic                i_nb_v,
    input  logic [W-1:0]        i_nb_val,
    output logic                o_v,
    output logic [W-1:0]        o_val,
    output logic                o_pass_v,
    output logic [W-1:0]        o_pass_val
);
    import splf_pkg::*;

    logic         r_v;
    logic [W-1:0] r_val;
    logic         r_pass_v;
    logic [W-1:0] r_pass_val;

    // Keep the smaller value, hand the larger one to the right neighbor; shift takes the neighbor's entry, clr empties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            r_pass_v <= 1'b0;
        end else if (i_ctl.clr) begin
            r_v      <= 1'b0;
            r_pass_v <= 1'b0;
        end else if (i_ctl.shift) begin
            r_v      <= i_nb_v;
            r_val    <= i_nb_val;
            r_pass_v <= 1'b0;
        end else begin
            r_pass_v <= 1'b0;
            if (i_ins_v) begin
                if (!r_v) begin
                    r_v   <= 1'b1;
                    r_val <= i_ins_val;
                end else if (i_ins_val < r_val) begin
                    r_val      <= i_ins_val;
                    r_pass_v   <= 1'b1;
                    r_pass_val <= r_val;
                end else begin
                    r_pass_v   <= 1'b1;
                    r_pass_val <= i_ins_val;
                end
            end
        end
    end

    assign o_v        = r_v;
    assign o_val      = r_val;
    assign o_pass_v   = r_pass_v;
    assign o_pass_val = r_pass_val;

endmodule

### src/scanline_polygon_row_fill.sv
// Top level of the scanline polygon row fill block (even-odd rule).
// Usage: op 1 appends a vertex and op 0 clears the polygon. A row request
// (op 2) walks the polygon edges one per cycle, but every edge that crosses
// the row first passes through a multiply and the bit-serial divide that
// finds the crossing x. The crossings are sorted in a chain of MAX_VERTICES
// cells, which is left to settle after the last crossing, and then shift
// out two per span; a pair waits while a finished span cannot go out. A
// row outside the polygon goes straight to its final transfer. Spans are
// delivered in order of increasing x, tlast on the final one; a row without
// pixels yields a single transfer with tuser low.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
`include "scanline_polygon_row_fill_defines.svh"

module scanline_polygon_row_fill #(
    parameter int unsigned MAX_VERTICES = 16,
    parameter int unsigned COORD_BITS   = 10
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [splf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [splf_pkg::CFG_BITS-1:0]          i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // vertex_x, vertex_y, row, zero pad
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // op
    input  logic [1:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // span_row, span_first, span_last_x, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // span_valid
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import splf_pkg::*;

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned DW    = ((3*COORD_BITS+7)/8)*8;
    localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
    localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int unsigned SW    = ((CB > CFG_BITS) ? CB : CFG_BITS) + 2;
    localparam int unsigned PW    = 2*CB + 2;
    localparam int unsigned QW    = 2*CB;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD0, S_EDGE, S_MUL, S_START, S_DIV,
        S_DRAIN, S_PAIR, S_SHIFT, S_FINAL
    } t_state;

    t_state                r_state;
    logic [CFG_BITS-1:0]   r_width;
    logic [CFG_BITS-1:0]   r_height;
    logic [CB-1:0]         r_vx [MAX_VERTICES];
    logic [CB-1:0]         r_vy [MAX_VERTICES];
    logic [CNT_W-1:0]      r_vcount;
    logic [CB-1:0]         r_lowy;
    logic [CB-1:0]         r_highy;
    logic [CB-1:0]         r_row;
    logic [CNT_W-1:0]      r_idx;
    logic [CB-1:0]         r_px;
    logic [CB-1:0]         r_py;
    logic signed [CB:0]    r_dx;
    logic signed [CB:0]    r_dy;
    logic signed [CB:0]    r_ty;
    logic [CB-1:0]         r_x1;
    logic signed [PW-1:0]  r_prod;
    logic                  r_neg;
    logic [CNT_W-1:0]      r_ncross;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_drain;
    logic                  r_pend_v;
    logic [CB-1:0]         r_pend_lo;
    logic [CB-1:0]         r_pend_hi;
    logic                  r_out_v;
    logic [CB-1:0]         r_out_row;
    logic [CB-1:0]         r_out_first;
    logic [CB-1:0]         r_out_last_x;
    logic                  r_out_span;
    logic                  r_out_last;

    // Input field views.
    logic [1:0]            w_op;
    logic [CB-1:0]         w_in_x;
    logic [CB-1:0]         w_in_y;
    logic [CB-1:0]         w_in_row;
    logic                  w_in_xfer;
    logic                  w_out_free;

    // Vertex read port.
    logic [CNT_W-1:0]      w_next;
    logic [IDX_W-1:0]      w_rd_idx;
    logic [CB-1:0]         w_cx;
    logic [CB-1:0]         w_cy;
    logic [CB-1:0]         w_ymin;
    logic [CB-1:0]         w_ymax;
    logic                  w_cross;
    logic                  w_short;
    logic                  w_row_ok;

    // Divider and crossing x.
    logic                  w_div_start;
    logic                  w_div_busy;
    logic                  w_div_done;
    logic [QW-1:0]         w_div_quo;
    logic signed [PW-1:0]  w_prod_abs;
    logic signed [CB:0]    w_dy_abs;
    logic [CB:0]           w_q;
    logic [CB:0]           w_xsum;

    // Sorting chain.
    t_cell_ctl             w_ctl;
    logic                  w_ins_v;
    logic [CB-1:0]         w_ins_val;
    logic                  w_cv   [MAX_VERTICES];
    logic [CB-1:0]         w_cval [MAX_VERTICES];
    logic                  w_pv   [MAX_VERTICES];
    logic [CB-1:0]         w_pval [MAX_VERTICES];

    // Span arithmetic.
    logic signed [SW-1:0]  w_lo;
    logic signed [SW-1:0]  w_hi;
    logic signed [SW-1:0]  w_xmax;
    logic                  w_span_ok;
    logic                  w_pair_go;
    logic                  w_out_load;

    assign w_op     = s_axis_tuser;
    assign w_in_x   = s_axis_tdata[CB-1:0];
    assign w_in_y   = s_axis_tdata[2*CB-1:CB];
    assign w_in_row = s_axis_tdata[3*CB-1:2*CB];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_v || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Walk the vertices; the edge under test runs from the held previous
    // vertex to the one read now, wrapping to vertex 0 after the last.
    always_comb begin
        w_next   = r_idx + 1'b1;
        if (r_state == S_LOAD0 || w_next == r_vcount) begin
            w_rd_idx = '0;
        end else begin
            w_rd_idx = w_next[IDX_W-1:0];
        end
        w_cx     = r_vx[w_rd_idx];
        w_cy     = r_vy[w_rd_idx];
        w_ymin   = (r_py < w_cy) ? r_py : w_cy;
        w_ymax   = (r_py < w_cy) ? w_cy : r_py;
        // Lower endpoint counts, upper does not; horizontal edges never cross.
        w_cross  = (r_py != w_cy) && (r_row >= w_ymin) && (r_row < w_ymax);
        w_short  = (r_vcount < CNT_W'(3)) || (w_in_row <= r_lowy) ||
                   (w_in_row >= r_highy);
        w_row_ok = (r_row != '0) && ({{(SW-CB){1'b0}}, r_row} <
                   {{(SW-CFG_BITS){1'b0}}, r_height});
    end

    always_comb begin
        w_prod_abs  = (r_prod < 0) ? -r_prod : r_prod;
        w_dy_abs    = (r_dy < 0) ? -r_dy : r_dy;
        w_div_start = (r_state == S_START);
        w_q         = r_neg ? -{1'b0, w_div_quo[CB-1:0]} : {1'b0, w_div_quo[CB-1:0]};
        w_xsum      = {1'b0, r_x1} + w_q;
        w_ins_v     = (r_state == S_DIV) && w_div_done;
        w_ins_val   = w_xsum[CB-1:0];
    end

    splf_div #(
        .NUM_W (QW),
        .DEN_W (CB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod_abs[QW-1:0]),
        .i_den   (w_dy_abs[CB-1:0]),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Pair up the two smallest crossings at the head of the chain.
    always_comb begin
        w_lo   = $signed({{(SW-CB){1'b0}}, w_cval[0]}) + SW'(1);
        w_hi   = $signed({{(SW-CB){1'b0}}, w_cval[1]}) - SW'(2);
        w_xmax = $signed({{(SW-CFG_BITS){1'b0}}, r_width}) - SW'(1);
        if (w_lo < SW'(1)) begin
            w_lo = SW'(1);
        end
        if (w_hi > w_xmax) begin
            w_hi = w_xmax;
        end
        w_span_ok = (w_lo <= w_hi);
        // Stall only when a finished span must go out and the output is full.
        w_pair_go = (r_state == S_PAIR) && (r_rem >= CNT_W'(2)) &&
                    !(w_span_ok && r_pend_v && !w_out_free);
        // The output register takes a new transfer in this cycle.
        w_out_load = (w_pair_go && w_span_ok && r_pend_v) ||
                     ((r_state == S_FINAL) && w_out_free);
        w_ctl.clr   = w_in_xfer && (w_op == OP_FILL);
        w_ctl.shift = w_pair_go || (r_state == S_SHIFT);
    end

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        logic          w_in_v;
        logic [CB-1:0] w_in_val;
        logic          w_nb_v;
        logic [CB-1:0] w_nb_val;

        if (k == 0) begin : g_head
            assign w_in_v   = w_ins_v;
            assign w_in_val = w_ins_val;
        end else begin : g_body
            assign w_in_v   = w_pv[k-1];
            assign w_in_val = w_pval[k-1];
        end
        if (k == MAX_VERTICES - 1) begin : g_tail
            assign w_nb_v   = 1'b0;
            assign w_nb_val = '0;
        end else begin : g_mid
            assign w_nb_v   = w_cv[k+1];
            assign w_nb_val = w_cval[k+1];
        end

        splf_cell #(
            .W (CB)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_ins_v    (w_in_v),
            .i_ins_val  (w_in_val),
            .i_nb_v     (w_nb_v),
            .i_nb_val   (w_nb_val),
            .o_v        (w_cv[k]),
            .o_val      (w_cval[k]),
            .o_pass_v   (w_pv[k]),
            .o_pass_val (w_pval[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_vcount <= '0;
            r_lowy   <= '0;
            r_highy  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_ncross <= '0;
            r_idx    <= '0;
            r_rem    <= '0;
            r_drain  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the taken transfer unless a new one loads this cycle.
            if (m_axis_tready && !w_out_load) begin
                r_out_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (w_op == OP_CLEAR) begin
                            r_vcount <= '0;
                            r_lowy   <= '0;
                            r_highy  <= '0;
                        end else if (w_op == OP_APPEND) begin
                            if (r_vcount < CNT_W'(MAX_VERTICES)) begin
                                r_vx[r_vcount[IDX_W-1:0]] <= w_in_x;
                                r_vy[r_vcount[IDX_W-1:0]] <= w_in_y;
                                r_vcount <= r_vcount + 1'b1;
                                if (r_vcount == '0 || w_in_y < r_lowy) begin
                                    r_lowy <= w_in_y;
                                end
                                if (r_vcount == '0 || w_in_y > r_highy) begin
                                    r_highy <= w_in_y;
                                end
                            end
                        end else if (w_op == OP_FILL) begin
                            r_row    <= w_in_row;
                            r_pend_v <= 1'b0;
                            r_ncross <= '0;
                            r_idx    <= '0;
                            r_state  <= w_short ? S_FINAL : S_LOAD0;
                        end
                    end
                end
                S_LOAD0: begin
                    r_px    <= w_cx;
                    r_py    <= w_cy;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_px  <= w_cx;
                    r_py  <= w_cy;
                    r_idx <= w_next;
                    if (w_cross) begin
                        r_dx    <= $signed({1'b0, w_cx}) - $signed({1'b0, r_px});
                        r_dy    <= $signed({1'b0, w_cy}) - $signed({1'b0, r_py});
                        r_ty    <= $signed({1'b0, r_row}) - $signed({1'b0, r_py});
                        r_x1    <= r_px;
                        r_state <= S_MUL;
                    end else if (w_next == r_vcount) begin
                        r_drain <= CNT_W'(MAX_VERTICES);
                        r_state <= S_DRAIN;
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(r_ty) * PW'(r_dx);
                    r_state <= S_START;
                end
                S_START: begin
                    r_neg   <= (r_prod < 0) ^ (r_dy < 0);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_ncross <= r_ncross + 1'b1;
                        if (r_idx == r_vcount) begin
                            r_drain <= CNT_W'(MAX_VERTICES);
                            r_state <= S_DRAIN;
                        end else begin
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_DRAIN: begin
                    // Let the last crossing ripple to its place in the chain.
                    r_drain <= r_drain - 1'b1;
                    if (r_drain == '0) begin
                        r_rem   <= r_ncross;
                        r_state <= w_row_ok ? S_PAIR : S_FINAL;
                    end
                end
                S_PAIR: begin
                    if (r_rem < CNT_W'(2)) begin
                        r_state <= S_FINAL;
                    end else if (w_pair_go) begin
                        if (w_span_ok) begin
                            if (r_pend_v) begin
                                r_out_v      <= 1'b1;
                                r_out_row    <= r_row;
                                r_out_first  <= r_pend_lo;
                                r_out_last_x <= r_pend_hi;
                                r_out_span   <= 1'b1;
                                r_out_last   <= 1'b0;
                            end
                            r_pend_v  <= 1'b1;
                            r_pend_lo <= w_lo[CB-1:0];
                            r_pend_hi <= w_hi[CB-1:0];
                        end
                        r_rem   <= r_rem - CNT_W'(2);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_state <= S_PAIR;
                end
                S_FINAL: begin
                    // Send the held span with tlast, or the empty result.
                    if (w_out_free) begin
                        r_out_v      <= 1'b1;
                        r_out_row    <= r_row;
                        r_out_first  <= r_pend_v ? r_pend_lo : '0;
                        r_out_last_x <= r_pend_v ? r_pend_hi : '0;
                        r_out_span   <= r_pend_v;
                        r_out_last   <= 1'b1;
                        r_pend_v     <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(DW-3*CB){1'b0}}, r_out_last_x, r_out_first, r_out_row};
    assign m_axis_tuser  = r_out_span;
    assign m_axis_tlast  = r_out_last;

    `SPLF_ASSERT_SAME(a_div_in_wait, w_div_busy, r_state == S_DIV)
    `SPLF_ASSERT_SAME(a_cross_bound, r_state != S_IDLE, r_ncross <= r_vcount)
    `SPLF_ASSERT_NEXT(a_fill_busy, w_in_xfer && (w_op == OP_FILL), !s_axis_tready)
    `SPLF_ASSERT_SAME(a_pend_state, r_pend_v,
        r_state == S_PAIR || r_state == S_SHIFT || r_state == S_FINAL)

endmodule

### tb/sv/scanline_polygon_row_fill_tb.sv
// Self-checking testbench for the scanline polygon row fill block.
`timescale 1ns / 1ps

module scanline_polygon_row_fill_tb;
    import splf_pkg::*;

    localparam int NV = 16;
    localparam int CB = 10;
    localparam int DW = ((3*CB+7)/8)*8;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]    op;
        logic [CB-1:0] vx;
        logic [CB-1:0] vy;
        logic [CB-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic [CB-1:0] row;
        logic [CB-1:0] first;
        logic [CB-1:0] last_x;
        logic          valid;
        logic          fin;
    } t_span;

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_BITS-1:0]  i_cfg_data;
    logic s_axis_tvalid, s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic m_axis_tvalid, m_axis_tready;
    logic [DW-1:0] m_axis_tdata;
    logic m_axis_tuser, m_axis_tlast;

    scanline_polygon_row_fill dut (.*);

    // Predictor state
    int poly_x[NV], poly_y[NV];
    int poly_n, poly_ylo, poly_yhi;
    int scr_w, scr_h;

    t_cmd  cmd_queue[$];
    t_span span_queue[$];
    int    errors;
    int    mismatches;
    bit    quiet_tx;    // hold sender steady
    bit    stall_rx;    // enable random receiver stall
    bit    gap_tx;      // enable random sender gaps
    longint cycles;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Work out the spans that one command causes and queue them; clear and append update the polygon.
    task automatic predict_spans(t_cmd c);
        int xs[NV];
        int cnt, y, j, k, v, lo, hi, nemit, y1, y2;
        t_span s;
        cnt = 0;
        nemit = 0;
        if (c.op == OP_CLEAR) begin
            poly_n = 0; poly_ylo = 0; poly_yhi = 0;
            return;
        end
        if (c.op == OP_APPEND) begin
            if (poly_n >= NV) return;
            poly_x[poly_n] = c.vx;
            poly_y[poly_n] = c.vy;
            if (poly_n == 0) begin
                poly_ylo = c.vy; poly_yhi = c.vy;
            end else begin
                if (c.vy < poly_ylo) poly_ylo = c.vy;
                if (c.vy > poly_yhi) poly_yhi = c.vy;
            end
            poly_n++;
            return;
        end
        if (c.op != OP_FILL) return;
        y = c.row;
        s = '0;
        s.row = c.row;
        if (poly_n >= 3 && y > poly_ylo && y < poly_yhi) begin
            for (int i = 0; i < poly_n; i++) begin
                k = (i + 1 < poly_n) ? i + 1 : 0;
                y1 = poly_y[i]; y2 = poly_y[k];
                if (y1 != y2 && ((y1 > y && y2 < y) || (y1 < y && y2 > y) ||
                        (y1 < y2 && y1 == y) || (y2 < y1 && y2 == y))) begin
                    xs[cnt] = poly_x[i] + ((y - y1) * (poly_x[k] - poly_x[i])) / (y2 - y1);
                    cnt++;
                end
            end
            for (int i = 1; i < cnt; i++) begin
                v = xs[i];
                j = i;
                while (j > 0 && xs[j-1] > v) begin
                    xs[j] = xs[j-1];
                    j--;
                end
                xs[j] = v;
            end
            if (y > 0 && y < scr_h) begin
                for (int i = 0; i + 1 < cnt; i += 2) begin
                    lo = xs[i] + 1;
                    hi = xs[i+1] - 2;
                    if (lo < 1) lo = 1;
                    if (hi > scr_w - 1) hi = scr_w - 1;
                    if (lo <= hi) begin
                        s.first = lo[CB-1:0];
                        s.last_x = hi[CB-1:0];
                        s.valid = 1'b1;
                        s.fin = 1'b0;
                        span_queue = {span_queue, s};
                        nemit++;
                    end
                end
            end
        end
        if (nemit == 0) begin
            s.first = '0; s.last_x = '0; s.valid = 1'b0; s.fin = 1'b1;
            span_queue = {span_queue, s};
        end else begin
            span_queue[$].fin = 1'b1;
        end
    endtask

    logic s_take;
    always @(posedge i_clk) begin
        s_take <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Driver: present one pending command, predict on acceptance, drive the receiver ready.
    always @(negedge i_clk) begin
        t_cmd c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_take) begin
                c = cmd_queue.pop_front();
                predict_spans(c);
            end
            if (s_axis_tvalid && !s_take) begin
                // Hold the waiting transfer until it is taken.
            end else if (cmd_queue.size() > 0 && !quiet_tx &&
                    !(gap_tx && $urandom_range(99) < 19)) begin
                c = cmd_queue[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= DW'({c.row, c.vy, c.vx});
                s_axis_tuser  <= c.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !(stall_rx && $urandom_range(99) < 19);
        end
    end

    // Monitor: compare each span transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_span got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.row    = m_axis_tdata[CB-1:0];
            got.first  = m_axis_tdata[2*CB-1:CB];
            got.last_x = m_axis_tdata[3*CB-1:2*CB];
            got.valid  = m_axis_tuser;
            got.fin    = m_axis_tlast;
            if (span_queue.size() == 0) begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected span row=%0d first=%0d last=%0d",
                             got.row, got.first, got.last_x);
            end else begin
                want = span_queue.pop_front();
                if (got !== want) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("span mismatch exp row=%0d %0d..%0d v=%0b l=%0b",
                                 want.row, want.first, want.last_x, want.valid,
                                 want.fin, " got row=%0d %0d..%0d v=%0b l=%0b",
                                 got.row, got.first, got.last_x, got.valid, got.fin);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("scanline_polygon_row_fill test failed");
            $finish;
        end
    end

    function automatic t_cmd mk(logic [1:0] op, int x, int y, int r);
        t_cmd c;
        c.op = op; c.vx = x[CB-1:0]; c.vy = y[CB-1:0]; c.row = r[CB-1:0];
        return c;
    endfunction

    // Append one command to the pending queue.
    function automatic void add_cmd(t_cmd c);
        cmd_queue = {cmd_queue, c};
    endfunction

    // Wait until every command is taken and every span has come back.
    task automatic drain();
        while (cmd_queue.size() > 0 || s_axis_tvalid || s_take)
            @(posedge i_clk);
        while (span_queue.size() > 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_BITS-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH) scr_w = val; else scr_h = val;
    endtask

    // Random polygon followed by a few row requests.
    task automatic queue_polygon(int nverts, int rows);
        int ymax;
        add_cmd(mk(OP_CLEAR, $urandom, $urandom, $urandom));
        ymax = ($urandom_range(3) == 0) ? 1023 : 700;
        for (int i = 0; i < nverts; i++)
            add_cmd(mk(OP_APPEND, $urandom_range(1023), $urandom_range(ymax), $urandom));
        for (int i = 0; i < rows; i++)
            add_cmd(mk(OP_FILL, $urandom, $urandom, $urandom_range(ymax)));
    endtask

    initial begin
        int w_set[4], h_set[4];
        w_set = '{800, 1024, 1, 37};
        h_set = '{600, 1024, 1, 500};
        errors = 0; mismatches = 0; cycles = 0;
        quiet_tx = 0; stall_rx = 0; gap_tx = 0;
        poly_n = 0; poly_ylo = 0; poly_yhi = 0;
        scr_w = WIDTH_RESET; scr_h = HEIGHT_RESET;
        i_rst_n = 0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 0;
        s_take = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: fewer than three vertices, undefined op, rectangle, extremes.
        add_cmd(mk(OP_FILL, 0, 0, 5));
        add_cmd(mk(OP_APPEND, 10, 10, 0));
        add_cmd(mk(OP_APPEND, 100, 10, 0));
        add_cmd(mk(OP_FILL, 0, 0, 10));
        add_cmd(mk(2'd3, 1023, 1023, 1023));
        add_cmd(mk(OP_APPEND, 100, 200, 0));
        add_cmd(mk(OP_APPEND, 10, 200, 0));
        add_cmd(mk(OP_FILL, 0, 0, 10));
        add_cmd(mk(OP_FILL, 0, 0, 11));
        add_cmd(mk(OP_FILL, 1023, 1023, 199));
        add_cmd(mk(OP_CLEAR, 0, 0, 0));
        // Wide concave quadrilateral reaching the screen edges, one row through two vertices.
        add_cmd(mk(OP_APPEND, 0, 0, 0));
        add_cmd(mk(OP_APPEND, 1023, 512, 0));
        add_cmd(mk(OP_APPEND, 0, 1023, 0));
        add_cmd(mk(OP_APPEND, 512, 512, 0));
        add_cmd(mk(OP_FILL, 0, 0, 512));
        add_cmd(mk(OP_FILL, 0, 0, 300));
        add_cmd(mk(OP_FILL, 0, 0, 700));
        add_cmd(mk(OP_FILL, 0, 0, 1022));
        // Overfill: 17 appends, the last one dropped.
        add_cmd(mk(OP_CLEAR, 0, 0, 0));
        for (int i = 0; i < 17; i++)
            add_cmd(mk(OP_APPEND, (i % 2) ? 900 - i * 10 : 50 + i * 20,
                       i * 40 + 10, 0));
        add_cmd(mk(OP_FILL, 0, 0, 333));
        add_cmd(mk(OP_FILL, 0, 0, 641));
        drain();

        // Random phases over screen settings, extremes included.
        for (int p = 0; p < 4; p++) begin
            write_cfg(CFG_SCREEN_WIDTH, w_set[p]);
            write_cfg(CFG_SCREEN_HEIGHT, h_set[p]);
            stall_rx = (p != 1);
            gap_tx = (p != 1);
            for (int k = 0; k < 3; k++)
                queue_polygon($urandom_range(3, (k == 0) ? 16 : 8), 3);
            if ($urandom_range(1)) queue_polygon(2, 1);
            add_cmd(mk(2'd3, $urandom, $urandom, $urandom));
            if (p == 2) begin
                // Hold the sender until every span is back, then resume.
                while (cmd_queue.size() > 8) @(posedge i_clk);
                quiet_tx = 1;
                while (s_axis_tvalid || s_take || span_queue.size() > 0)
                    @(posedge i_clk);
                @(negedge i_clk);
                quiet_tx = 0;
            end
            drain();
        end

        if (errors == 0)
            $display("scanline_polygon_row_fill test passed");
        else
            $display("scanline_polygon_row_fill test failed");
        $finish;
    end
endmodule
